/* hdl/ppg_dc_removal_mean_diff_filter_defines.svh */
// Assertion macros shared by the filter's modules.
`ifndef PPG_DC_REMOVAL_MEAN_DIFF_FILTER_DEFINES_SVH
`define PPG_DC_REMOVAL_MEAN_DIFF_FILTER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PPGDC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PPGDC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/ppgdc_pkg.sv */
package ppgdc_pkg;

    localparam int WINDOW_DEF      = 15;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam int ALPHA_W = 16;
    localparam int LEVEL_W = 24;
    localparam int AC_W    = 25;
    localparam int DIFF_W  = 26;
    localparam int PROD_W  = ALPHA_W + LEVEL_W;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX = {LEVEL_W{1'b1}};

    localparam logic [ALPHA_W-1:0] ALPHA_IR_RST  = 16'd58982;
    localparam logic [ALPHA_W-1:0] ALPHA_RED_RST = 16'd62259;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA_IR  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA_RED = 2'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPD,
        ST_DSTART,
        ST_DIV,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic mul_en;
        logic upd_en;
    } t_dc_ctrl;

endpackage

/* hdl/ppgdc_ram.sv */
module ppgdc_ram #(
    parameter int WIDTH = 25,
    parameter int DEPTH = 15
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic                                    i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/ppgdc_dc.sv */
module ppgdc_dc #(
    parameter int SAMPLE_BITS = ppgdc_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  ppgdc_pkg::t_dc_ctrl                 i_ctrl,
    input  logic [SAMPLE_BITS-1:0]              i_sample,
    input  logic [ppgdc_pkg::ALPHA_W-1:0]       i_alpha,
    output logic signed [ppgdc_pkg::AC_W-1:0]   o_ac
);
    import ppgdc_pkg::*;

    logic [LEVEL_W-1:0] r_level;
    logic [LEVEL_W-1:0] n_level;
    logic [PROD_W-1:0]  r_prod;
    logic [SAMPLE_BITS-1:0] r_sample;
    logic [PROD_W-1:0]  w_prod;
    logic [LEVEL_W:0]   w_sum;

    assign w_prod = PROD_W'(i_alpha) * PROD_W'(r_level);
    assign w_sum  = (LEVEL_W + 1)'(r_sample) + {1'b0, r_prod[PROD_W-1:ALPHA_W]};

    always_comb begin
        n_level = w_sum[LEVEL_W] ? LEVEL_MAX : w_sum[LEVEL_W-1:0];
    end

    assign o_ac = $signed({1'b0, n_level}) - $signed({1'b0, r_level});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= '0;
        end else if (i_ctrl.upd_en) begin
            r_level <= n_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.mul_en) begin
            r_prod   <= w_prod;
            r_sample <= i_sample;
        end
    end

endmodule

/* hdl/ppgdc_div.sv */
module ppgdc_div #(
    parameter int WINDOW = ppgdc_pkg::WINDOW_DEF
) (
    input  logic                                            i_clk,
    input  logic                                            i_rst_n,
    input  logic                                            i_start,
    input  logic signed [ppgdc_pkg::AC_W+$clog2(WINDOW)-1:0] i_dividend,
    input  logic [$clog2(WINDOW+1)-1:0]                     i_divisor,
    output logic                                            o_done,
    output logic signed [ppgdc_pkg::DIFF_W-1:0]             o_quot
);
    import ppgdc_pkg::*;

    localparam int SUM_W  = AC_W + $clog2(WINDOW);
    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int STEP_W = $clog2(SUM_W + 1);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic              r_neg;
    logic [SUM_W-1:0]  r_num;
    logic [SUM_W-1:0]  r_quo;
    logic [CNT_W-1:0]  r_rem;
    logic [CNT_W-1:0]  r_div;

    logic [CNT_W:0]      w_trial;
    logic                w_ge;
    logic [CNT_W:0]      w_rem_next;
    logic signed [SUM_W:0] w_q_ext;

    assign w_trial    = {r_rem, r_num[SUM_W-1]};
    assign w_ge       = w_trial >= {1'b0, r_div};
    assign w_rem_next = w_ge ? (w_trial - {1'b0, r_div}) : w_trial;
    assign w_q_ext    = $signed({1'b0, r_quo});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(SUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_dividend[SUM_W-1];
            r_num <= i_dividend[SUM_W-1] ? SUM_W'(-i_dividend) : i_dividend;
            r_quo <= '0;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_num <= {r_num[SUM_W-2:0], 1'b0};
            r_quo <= {r_quo[SUM_W-2:0], w_ge};
            r_rem <= w_rem_next[CNT_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? DIFF_W'(-w_q_ext) : DIFF_W'(w_q_ext);

    `include "ppg_dc_removal_mean_diff_filter_defines.svh"

    `PPGDC_ASSERT_NOW(a_div_start_idle, i_start, !r_busy, "divider started while busy")
    `PPGDC_ASSERT_NEXT(a_div_done_ends, r_done, !r_busy && !r_done, "done pulse not single")
    `PPGDC_ASSERT_NOW(a_div_rem_range, r_busy, r_rem < r_div, "remainder out of range")

endmodule

/* hdl/ppg_dc_removal_mean_diff_filter.sv */
// Channel   Handshake                      Payload
// input     i_in_valid / o_in_ready        i_raw_ir, i_raw_red
// output    o_out_valid / i_out_ready      o_ac_ir, o_ac_red, o_mean_diff_ir
// config    i_cfg_we (no wait)             i_cfg_index, i_cfg_data
//
// A request passes through ST_UPD, ST_DSTART, ST_DIV and ST_OUT before its result is presented;
// the next request is taken only back in ST_IDLE, not before the last one is through.
// The serial divider for the window average works out one quotient bit per cycle.
// Reset is synchronous and clears the levels, the window sum, position and fill count.
// The window memory needs no clearing; entries not yet written are taken as zero.
// A new request is taken while a finished result waits; the divider result holds until the
// output register is free.
module ppg_dc_removal_mean_diff_filter #(
    parameter int WINDOW      = ppgdc_pkg::WINDOW_DEF,
    parameter int SAMPLE_BITS = ppgdc_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic [SAMPLE_BITS-1:0]                i_raw_ir,
    input  logic [SAMPLE_BITS-1:0]                i_raw_red,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic signed [ppgdc_pkg::AC_W-1:0]     o_ac_ir,
    output logic signed [ppgdc_pkg::AC_W-1:0]     o_ac_red,
    output logic signed [ppgdc_pkg::DIFF_W-1:0]   o_mean_diff_ir,
    input  logic                                  i_cfg_we,
    input  logic [ppgdc_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [ppgdc_pkg::ALPHA_W-1:0]         i_cfg_data
);
    import ppgdc_pkg::*;

    localparam int SUM_W = AC_W + $clog2(WINDOW);
    localparam int CNT_W = $clog2(WINDOW + 1);
    localparam int POS_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;

    t_state r_state;
    t_state n_state;

    logic [ALPHA_W-1:0]     r_alpha_ir;
    logic [ALPHA_W-1:0]     r_alpha_red;
    logic signed [SUM_W-1:0] r_sum;
    logic signed [SUM_W-1:0] n_sum;
    logic [POS_W-1:0]       r_pos;
    logic [POS_W-1:0]       n_pos;
    logic [CNT_W-1:0]       r_fill;
    logic [CNT_W-1:0]       n_fill;
    logic signed [AC_W-1:0] r_ac_ir;
    logic signed [AC_W-1:0] r_ac_red;
    logic                   r_out_valid;
    logic signed [AC_W-1:0] r_out_ac_ir;
    logic signed [AC_W-1:0] r_out_ac_red;
    logic signed [DIFF_W-1:0] r_out_diff;

    logic                   w_accept;
    logic                   w_out_take;
    logic                   w_out_load;
    logic                   w_ram_we;
    logic                   w_div_start;
    logic                   w_div_done;
    t_dc_ctrl               w_dc_ctrl;
    logic [AC_W-1:0]        w_ram_rdata;
    logic signed [AC_W-1:0] w_old;
    logic signed [AC_W-1:0] w_ac_ir;
    logic signed [AC_W-1:0] w_ac_red;
    logic signed [DIFF_W-1:0] w_quot;

    assign w_accept   = i_in_valid && o_in_ready;
    assign w_out_take = r_out_valid && i_out_ready;

    always_comb begin
        n_state     = r_state;
        o_in_ready  = 1'b0;
        w_ram_we    = 1'b0;
        w_div_start = 1'b0;
        w_out_load  = 1'b0;
        w_dc_ctrl   = '0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready       = 1'b1;
                w_dc_ctrl.mul_en = i_in_valid;
                if (i_in_valid) begin
                    n_state = ST_UPD;
                end
            end
            ST_UPD: begin
                w_dc_ctrl.upd_en = 1'b1;
                w_ram_we         = 1'b1;
                n_state          = ST_DSTART;
            end
            ST_DSTART: begin
                w_div_start = 1'b1;
                n_state     = ST_DIV;
            end
            ST_DIV: begin
                if (w_div_done) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    w_out_load = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha_ir  <= ALPHA_IR_RST;
            r_alpha_red <= ALPHA_RED_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_ALPHA_IR:  r_alpha_ir  <= i_cfg_data;
                REG_ALPHA_RED: r_alpha_red <= i_cfg_data;
                default: ;
            endcase
        end
    end

    ppgdc_dc #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dc_ir (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (w_dc_ctrl),
        .i_sample (i_raw_ir),
        .i_alpha  (r_alpha_ir),
        .o_ac     (w_ac_ir)
    );

    ppgdc_dc #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dc_red (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (w_dc_ctrl),
        .i_sample (i_raw_red),
        .i_alpha  (r_alpha_red),
        .o_ac     (w_ac_red)
    );

    ppgdc_ram #(
        .WIDTH (AC_W),
        .DEPTH (WINDOW)
    ) u_window_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_pos),
        .i_wdata (w_ac_ir),
        .i_re    (w_accept),
        .i_raddr (r_pos),
        .o_rdata (w_ram_rdata)
    );

    // Until the window has filled once, the slot being replaced has never been written.
    assign w_old = (r_fill < CNT_W'(WINDOW)) ? '0 : $signed(w_ram_rdata);

    always_comb begin
        n_sum  = r_sum - SUM_W'(w_old) + SUM_W'(w_ac_ir);
        n_pos  = (r_pos == POS_W'(WINDOW - 1)) ? '0 : r_pos + 1'b1;
        n_fill = (r_fill < CNT_W'(WINDOW)) ? r_fill + 1'b1 : r_fill;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum  <= '0;
            r_pos  <= '0;
            r_fill <= '0;
        end else if (r_state == ST_UPD) begin
            r_sum  <= n_sum;
            r_pos  <= n_pos;
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_UPD) begin
            r_ac_ir  <= w_ac_ir;
            r_ac_red <= w_ac_red;
        end
    end

    ppgdc_div #(
        .WINDOW (WINDOW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_sum),
        .i_divisor  (r_fill),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (w_out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_ac_ir  <= r_ac_ir;
            r_out_ac_red <= r_ac_red;
            r_out_diff   <= w_quot - DIFF_W'(r_ac_ir);
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_ac_ir        = r_out_ac_ir;
    assign o_ac_red       = r_out_ac_red;
    assign o_mean_diff_ir = r_out_diff;

    `include "ppg_dc_removal_mean_diff_filter_defines.svh"

    `PPGDC_ASSERT_NEXT(a_accept_blocks, w_accept, !o_in_ready, "request taken while busy")
    `PPGDC_ASSERT_NOW(a_done_in_div, w_div_done, r_state == ST_DIV, "divider done out of turn")
    `PPGDC_ASSERT_NOW(a_ram_no_overlap, w_ram_we, !w_accept, "window read and write overlap")
    `PPGDC_ASSERT_NOW(a_pos_range, 1'b1, int'(r_pos) < WINDOW, "window position out of range")
    `PPGDC_ASSERT_NEXT(a_out_load, w_out_load, o_out_valid, "result not presented")

endmodule
